FILE: rtl/b32m_pkg.sv
// b32m_pkg: shared types, codes and constants of the bech32/bech32m address encoder
// no dependencies; imported by b32m_ctrl, b32m_dp and the top level
package b32m_pkg;

   typedef enum logic [1:0] {
      REQ_PREFIX  = 2'd0,
      REQ_VERSION = 2'd1,
      REQ_BYTE    = 2'd2,
      REQ_FINISH  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_PREFIX_LONG  = 3'd1,
      ERR_NO_PROGRAM   = 3'd2,
      ERR_ORDER        = 3'd3,
      ERR_PROGRAM_LONG = 3'd4
   } err_type;

   typedef enum logic [2:0] {
      OUT_PREFIX = 3'd0,
      OUT_ONE    = 3'd1,
      OUT_SYMBOL = 3'd2,
      OUT_CSUM   = 3'd3,
      OUT_ERROR  = 3'd4
   } out_sel_type;

   typedef enum logic [1:0] {
      GRP_VERSION = 2'd0,
      GRP_FIRST   = 2'd1,
      GRP_SECOND  = 2'd2,
      GRP_PAD     = 2'd3
   } grp_sel_type;

   typedef enum logic [1:0] {
      MIX_ZERO  = 2'd0,
      MIX_HIGH  = 2'd1,
      MIX_MEM   = 2'd2,
      MIX_GROUP = 2'd3
   } mix_sel_type;

   typedef struct packed {
      logic        capture;
      logic        emit;
      out_sel_type out_sel;
      grp_sel_type grp_sel;
      logic        out_last;
      err_type     err;
      logic        mix;
      mix_sel_type mix_sel;
      logic        prefix_store;
      logic        byte_update;
      logic        replay_start;
      logic        replay_next;
      logic        version_set;
      logic        csum_xor;
      logic [2:0]  csum_idx;
      logic        clear;
   } b32m_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         phase_prog;
      logic         prefix_full;
      logic         program_full;
      logic         program_none;
      logic         rc_nonzero;
      logic         rc_two;
      logic         replay_done;
      logic         out_free;
   } b32m_sts_type;

   localparam int          CSUM_LEN  = 6;
   localparam logic [29:0] CSUM_INIT = 30'd1;
   localparam logic [29:0] CONST_V0  = 30'd1;
   localparam logic [29:0] CONST_VN  = 30'h2bc830a3;
   localparam logic [6:0]  CHAR_ONE  = 7'h31;

   localparam logic [29:0] GEN [5] = '{
      30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
   };

   // qpzry9x8gf2tvdw0s3jn54khce6mua7l
   localparam logic [6:0] ALPHABET [32] = '{
      7'd113, 7'd112, 7'd122, 7'd114, 7'd121, 7'd57,  7'd120, 7'd56,
      7'd103, 7'd102, 7'd50,  7'd116, 7'd118, 7'd100, 7'd119, 7'd48,
      7'd115, 7'd51,  7'd106, 7'd110, 7'd53,  7'd52,  7'd107, 7'd104,
      7'd99,  7'd101, 7'd54,  7'd109, 7'd117, 7'd97,  7'd55,  7'd108
   };

   function automatic logic [29:0] b32m_mix(input logic [29:0] c, input logic [4:0] v);
      logic [29:0] r;
      logic [4:0]  top;
      top = c[29:25];
      r   = {c[24:0], v};
      for (int i = 0; i < 5; i++) begin
         if (top[i]) begin
            r = r ^ GEN[i];
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/b32m_if.sv
// b32m_req_if, b32m_rsp_if: valid/ready channels of the address encoder
// no dependencies
interface b32m_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [6:0] prefix_char;
   logic [4:0] seg_version;
   logic [7:0] program_byte;

   modport source (output valid, req_type, prefix_char, seg_version, program_byte,
                   input ready);
   modport sink (input valid, req_type, prefix_char, seg_version, program_byte,
                 output ready);
endinterface

interface b32m_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       last;
   logic [2:0] error;

   modport source (output valid, out_char, last, error, input ready);
   modport sink (input valid, out_char, last, error, output ready);
endinterface

FILE: rtl/b32m_ctrl.sv
// b32m_ctrl: sequencing state machine of the address encoder
// depends on b32m_pkg; drives b32m_dp through b32m_cmd_type
module b32m_ctrl
   import b32m_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  b32m_sts_type sts,
   output b32m_cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DISPATCH = 7'b0000010,
      S_REPLAY   = 7'b0000100,
      S_BYTE2    = 7'b0001000,
      S_ZERO     = 7'b0010000,
      S_FINAL    = 7'b0100000,
      S_CSUM     = 7'b1000000
   } state_type;

   localparam logic [2:0] STEP_LAST = 3'(CSUM_LEN - 1);

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;
   err_type    err;

   // request checks against the current phase and counts
   always_comb begin
      err = ERR_NONE;
      unique case (sts.kind)
         REQ_PREFIX: begin
            if (sts.phase_prog) err = ERR_ORDER;
            else if (sts.prefix_full) err = ERR_PREFIX_LONG;
         end
         REQ_VERSION: begin
            if (sts.phase_prog) err = ERR_ORDER;
         end
         REQ_BYTE: begin
            if (!sts.phase_prog) err = ERR_ORDER;
            else if (sts.program_full) err = ERR_PROGRAM_LONG;
         end
         REQ_FINISH: begin
            if (!sts.phase_prog) err = ERR_ORDER;
            else if (sts.program_none) err = ERR_NO_PROGRAM;
         end
         default: err = ERR_NONE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (err != ERR_NONE) begin
               if (sts.out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.out_sel  = OUT_ERROR;
                  cmd.out_last = 1'b1;
                  cmd.err      = err;
                  cmd.clear    = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               unique case (sts.kind)
                  REQ_PREFIX: begin
                     if (sts.out_free) begin
                        cmd.emit         = 1'b1;
                        cmd.out_sel      = OUT_PREFIX;
                        cmd.mix          = 1'b1;
                        cmd.mix_sel      = MIX_HIGH;
                        cmd.prefix_store = 1'b1;
                        state_in         = S_IDLE;
                     end
                  end
                  REQ_VERSION: begin
                     if (sts.out_free) begin
                        cmd.emit         = 1'b1;
                        cmd.out_sel      = OUT_ONE;
                        cmd.mix          = 1'b1;
                        cmd.mix_sel      = MIX_ZERO;
                        cmd.replay_start = 1'b1;
                        state_in         = S_REPLAY;
                     end
                  end
                  REQ_BYTE: begin
                     if (sts.out_free) begin
                        cmd.emit    = 1'b1;
                        cmd.out_sel = OUT_SYMBOL;
                        cmd.grp_sel = GRP_FIRST;
                        cmd.mix     = 1'b1;
                        cmd.mix_sel = MIX_GROUP;
                        if (sts.rc_two) begin
                           state_in = S_BYTE2;
                        end else begin
                           cmd.byte_update = 1'b1;
                           state_in        = S_IDLE;
                        end
                     end
                  end
                  REQ_FINISH: begin
                     step_in = '0;
                     if (!sts.rc_nonzero) begin
                        state_in = S_ZERO;
                     end else if (sts.out_free) begin
                        cmd.emit    = 1'b1;
                        cmd.out_sel = OUT_SYMBOL;
                        cmd.grp_sel = GRP_PAD;
                        cmd.mix     = 1'b1;
                        cmd.mix_sel = MIX_GROUP;
                        state_in    = S_ZERO;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_REPLAY: begin
            if (!sts.replay_done) begin
               cmd.mix         = 1'b1;
               cmd.mix_sel     = MIX_MEM;
               cmd.replay_next = 1'b1;
            end else if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.out_sel     = OUT_SYMBOL;
               cmd.grp_sel     = GRP_VERSION;
               cmd.mix         = 1'b1;
               cmd.mix_sel     = MIX_GROUP;
               cmd.version_set = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_BYTE2: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.out_sel     = OUT_SYMBOL;
               cmd.grp_sel     = GRP_SECOND;
               cmd.mix         = 1'b1;
               cmd.mix_sel     = MIX_GROUP;
               cmd.byte_update = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_ZERO: begin
            cmd.mix     = 1'b1;
            cmd.mix_sel = MIX_ZERO;
            step_in     = step_ff + 3'd1;
            if (step_ff == STEP_LAST) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            cmd.csum_xor = 1'b1;
            step_in      = '0;
            state_in     = S_CSUM;
         end
         S_CSUM: begin
            cmd.csum_idx = step_ff;
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.out_sel  = OUT_CSUM;
               cmd.out_last = (step_ff == STEP_LAST);
               step_in      = step_ff + 3'd1;
               if (step_ff == STEP_LAST) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

FILE: rtl/b32m_dp.sv
// b32m_dp: checksum, prefix store, bit regrouping and result register
// depends on b32m_pkg and b32m_rsp_if; controlled by b32m_ctrl
module b32m_dp
   import b32m_pkg::*;
#(
   parameter int MAX_PREFIX  = 83,
   parameter int MAX_PROGRAM = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        req_type,
   input  logic [6:0]        prefix_char,
   input  logic [4:0]        seg_version,
   input  logic [7:0]        program_byte,
   b32m_rsp_if.source        rsp,
   input  b32m_cmd_type      cmd,
   output b32m_sts_type      sts
);

   localparam int PW = $clog2(MAX_PREFIX + 1);
   localparam int AW = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
   localparam int GW = $clog2(MAX_PROGRAM + 1);

   // captured request
   req_kind_type kind_ff;
   logic [6:0]   char_ff;
   logic [4:0]   ver_ff;
   logic [7:0]   byte_ff;

   logic [29:0]   checksum_ff, checksum_in;
   logic [PW-1:0] prefix_count_ff, prefix_count_in;
   logic [PW-1:0] rd_idx_ff, rd_idx_in;
   logic [3:0]    residue_ff, residue_in;
   logic [2:0]    rc_ff, rc_in;
   logic          phase_ff, phase_in;
   logic          vzero_ff, vzero_in;
   logic [GW-1:0] program_count_ff, program_count_in;

   logic [4:0] mem [MAX_PREFIX];
   logic [4:0] mem_q_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] out_char_ff, out_char_in;
   logic       last_ff;
   err_type    err_ff;

   logic [11:0] acc;
   logic [3:0]  sh_first;
   logic [2:0]  sh_second;
   logic [2:0]  rc_next;
   logic [3:0]  mask;
   logic [4:0]  g_first, g_second, g_pad, group, mix_val, csum_grp;
   logic        out_free;

   assign acc       = {residue_ff, byte_ff};
   assign sh_first  = {1'b0, rc_ff} + 4'd3;
   assign sh_second = rc_ff - 3'd2;
   assign g_first   = 5'(acc >> sh_first);
   assign g_second  = 5'(acc >> sh_second);
   assign g_pad     = 5'({1'b0, residue_ff} << (3'd5 - rc_ff));
   assign rc_next   = (rc_ff >= 3'd2) ? (rc_ff - 3'd2) : (rc_ff + 3'd3);
   assign mask      = 4'((5'd1 << rc_next) - 5'd1);

   always_comb begin
      unique case (cmd.grp_sel)
         GRP_VERSION: group = ver_ff;
         GRP_FIRST:   group = g_first;
         GRP_SECOND:  group = g_second;
         GRP_PAD:     group = g_pad;
         default:     group = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.mix_sel)
         MIX_ZERO:  mix_val = '0;
         MIX_HIGH:  mix_val = {3'b000, char_ff[6:5]};
         MIX_MEM:   mix_val = mem_q_ff;
         MIX_GROUP: mix_val = group;
         default:   mix_val = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.csum_idx)
         3'd0:    csum_grp = checksum_ff[29:25];
         3'd1:    csum_grp = checksum_ff[24:20];
         3'd2:    csum_grp = checksum_ff[19:15];
         3'd3:    csum_grp = checksum_ff[14:10];
         3'd4:    csum_grp = checksum_ff[9:5];
         3'd5:    csum_grp = checksum_ff[4:0];
         default: csum_grp = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.out_sel)
         OUT_PREFIX: out_char_in = char_ff;
         OUT_ONE:    out_char_in = CHAR_ONE;
         OUT_SYMBOL: out_char_in = ALPHABET[group];
         OUT_CSUM:   out_char_in = ALPHABET[csum_grp];
         OUT_ERROR:  out_char_in = '0;
         default:    out_char_in = '0;
      endcase
   end

   always_comb begin
      checksum_in      = checksum_ff;
      prefix_count_in  = prefix_count_ff;
      residue_in       = residue_ff;
      rc_in            = rc_ff;
      phase_in         = phase_ff;
      vzero_in         = vzero_ff;
      program_count_in = program_count_ff;
      priority if (cmd.clear) begin
         checksum_in      = CSUM_INIT;
         prefix_count_in  = '0;
         residue_in       = '0;
         rc_in            = '0;
         phase_in         = 1'b0;
         vzero_in         = 1'b0;
         program_count_in = '0;
      end else begin
         if (cmd.csum_xor) begin
            checksum_in = checksum_ff ^ (vzero_ff ? CONST_V0 : CONST_VN);
         end else if (cmd.mix) begin
            checksum_in = b32m_mix(checksum_ff, mix_val);
         end
         if (cmd.prefix_store) begin
            prefix_count_in = prefix_count_ff + PW'(1);
         end
         if (cmd.byte_update) begin
            residue_in       = acc[3:0] & mask;
            rc_in            = rc_next;
            program_count_in = program_count_ff + GW'(1);
         end
         if (cmd.version_set) begin
            phase_in = 1'b1;
            vzero_in = (ver_ff == 5'd0);
         end
      end
   end

   always_comb begin
      priority if (cmd.replay_start) rd_idx_in = '0;
      else if (cmd.replay_next) rd_idx_in = rd_idx_ff + PW'(1);
      else rd_idx_in = rd_idx_ff;
   end

   assign out_free     = !rsp_valid_ff || rsp.ready;
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         checksum_ff      <= CSUM_INIT;
         prefix_count_ff  <= '0;
         rd_idx_ff        <= '0;
         residue_ff       <= '0;
         rc_ff            <= '0;
         phase_ff         <= 1'b0;
         vzero_ff         <= 1'b0;
         program_count_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         checksum_ff      <= checksum_in;
         prefix_count_ff  <= prefix_count_in;
         rd_idx_ff        <= rd_idx_in;
         residue_ff       <= residue_in;
         rc_ff            <= rc_in;
         phase_ff         <= phase_in;
         vzero_ff         <= vzero_in;
         program_count_ff <= program_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind_type'(req_type);
         char_ff <= prefix_char;
         ver_ff  <= seg_version;
         byte_ff <= program_byte;
      end
      if (cmd.emit) begin
         out_char_ff <= out_char_in;
         last_ff     <= cmd.out_last;
         err_ff      <= cmd.err;
      end
   end

   // prefix low bits, replayed when the version arrives
   always_ff @(posedge clock) begin
      if (cmd.prefix_store) begin
         mem[prefix_count_ff[AW-1:0]] <= char_ff[4:0];
      end
      mem_q_ff <= mem[rd_idx_in[AW-1:0]];
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_char = out_char_ff;
   assign rsp.last     = last_ff;
   assign rsp.error    = err_ff;

   assign sts.kind         = kind_ff;
   assign sts.phase_prog   = phase_ff;
   assign sts.prefix_full  = (prefix_count_ff == PW'(MAX_PREFIX));
   assign sts.program_full = (program_count_ff == GW'(MAX_PROGRAM));
   assign sts.program_none = (program_count_ff == '0);
   assign sts.rc_nonzero   = (rc_ff != 3'd0);
   assign sts.rc_two       = (rc_ff >= 3'd2);
   assign sts.replay_done  = (rd_idx_ff == prefix_count_ff);
   assign sts.out_free     = out_free;

endmodule

FILE: rtl/bech32m_address_encoder_top.sv
// each request takes longer while a result waits on rsp.ready
// throughput: one request at a time; the version request walks the prefix store one entry
// a cycle and finish runs six serial checksum steps before its six characters
// reset: synchronous, active high; clears checksum, counts and phase, not the prefix store
// depends on b32m_pkg, b32m_if, b32m_ctrl and b32m_dp
module bech32m_address_encoder_top
   import b32m_pkg::*;
#(
   parameter int MAX_PREFIX  = 83,
   parameter int MAX_PROGRAM = 40
) (
   input logic        clock,
   input logic        reset,
   b32m_req_if.sink   req,
   b32m_rsp_if.source rsp
);

   b32m_cmd_type cmd;
   b32m_sts_type sts;
   logic         req_ready;

   assign req.ready = req_ready;

   b32m_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   b32m_dp #(
      .MAX_PREFIX  (MAX_PREFIX),
      .MAX_PROGRAM (MAX_PROGRAM)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_type     (req.req_type),
      .prefix_char  (req.prefix_char),
      .seg_version  (req.seg_version),
      .program_byte (req.program_byte),
      .rsp          (rsp),
      .cmd          (cmd),
      .sts          (sts)
   );

`ifndef SYNTH
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result register overwritten");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.error != ERR_NONE)) |-> (rsp.last && (rsp.out_char == 7'd0)))
      else $error("error result without last or with a character");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request taken while one is in progress");
`endif

endmodule

FILE: tb/b32m_addr_checker.sv
// b32m_addr_checker: watches the request and response channels of the address encoder,
// predicts the encoded characters of every request and compares them with the responses
// depends on b32m_pkg and b32m_if
`timescale 1ns / 100ps

module b32m_addr_checker
   import b32m_pkg::*;
#(
   parameter int MAX_PREFIX  = 83,
   parameter int MAX_PROGRAM = 40
) (
   input logic  clock,
   input logic  reset,
   b32m_req_if  req,
   b32m_rsp_if  rsp,
   output int   mismatches,
   output int   expected_left
);

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
      err_type    err;
   } addr_char_type;

   addr_char_type expected_chars[$];

   logic [29:0] csum;
   logic [4:0]  prefix_low [MAX_PREFIX];
   int          prefix_len;
   logic [3:0]  residue;
   int          residue_bits;
   logic        in_program;
   logic        ver_zero;
   int          prog_len;

   function automatic logic [29:0] csum_step(input logic [29:0] c, input logic [4:0] sym);
      logic [29:0] r;
      r = {c[24:0], sym};
      for (int k = 0; k < 5; k++) begin
         if (c[25 + k]) begin
            r = r ^ GEN[k];
         end
      end
      return r;
   endfunction

   task automatic clear_state();
      csum         = CSUM_INIT;
      prefix_len   = 0;
      residue      = '0;
      residue_bits = 0;
      in_program   = 1'b0;
      ver_zero     = 1'b0;
      prog_len     = 0;
   endtask

   task automatic push_char(input logic [6:0] ch, input logic last, input err_type err);
      addr_char_type c;
      c.ch   = ch;
      c.last = last;
      c.err  = err;
      expected_chars.push_back(c);
   endtask

   task automatic abort_address(input err_type err);
      clear_state();
      push_char(7'd0, 1'b1, err);
   endtask

   task automatic encode_request(input req_kind_type kind, input logic [6:0] pc,
                                 input logic [4:0] wv, input logic [7:0] pb);
      logic [11:0] acc;
      logic [4:0]  grp;
      logic [29:0] fin;
      int          bits;
      unique case (kind)
         REQ_PREFIX: begin
            if (in_program) begin
               abort_address(ERR_ORDER);
            end else if (prefix_len >= MAX_PREFIX) begin
               abort_address(ERR_PREFIX_LONG);
            end else begin
               csum = csum_step(csum, {3'b000, pc[6:5]});
               prefix_low[prefix_len] = pc[4:0];
               prefix_len++;
               push_char(pc, 1'b0, ERR_NONE);
            end
         end
         REQ_VERSION: begin
            if (in_program) begin
               abort_address(ERR_ORDER);
            end else begin
               csum = csum_step(csum, 5'd0);
               for (int k = 0; k < prefix_len; k++) begin
                  csum = csum_step(csum, prefix_low[k]);
               end
               csum       = csum_step(csum, wv);
               ver_zero   = (wv == 5'd0);
               in_program = 1'b1;
               push_char(CHAR_ONE, 1'b0, ERR_NONE);
               push_char(ALPHABET[wv], 1'b0, ERR_NONE);
            end
         end
         REQ_BYTE: begin
            if (!in_program) begin
               abort_address(ERR_ORDER);
            end else if (prog_len >= MAX_PROGRAM) begin
               abort_address(ERR_PROGRAM_LONG);
            end else begin
               acc  = {residue, pb};
               bits = residue_bits + 8;
               while (bits >= 5) begin
                  bits = bits - 5;
                  grp  = acc[bits +: 5];
                  csum = csum_step(csum, grp);
                  push_char(ALPHABET[grp], 1'b0, ERR_NONE);
               end
               residue      = 4'(acc & ((12'd1 << bits) - 12'd1));
               residue_bits = bits;
               prog_len++;
            end
         end
         default: begin
            if (!in_program) begin
               abort_address(ERR_ORDER);
            end else if (prog_len == 0) begin
               abort_address(ERR_NO_PROGRAM);
            end else begin
               // leftover bits are padded with zeros up to a full group
               if (residue_bits != 0) begin
                  grp  = 5'({1'b0, residue} << (5 - residue_bits));
                  csum = csum_step(csum, grp);
                  push_char(ALPHABET[grp], 1'b0, ERR_NONE);
               end
               for (int k = 0; k < CSUM_LEN; k++) begin
                  csum = csum_step(csum, 5'd0);
               end
               fin = csum ^ (ver_zero ? CONST_V0 : CONST_VN);
               for (int k = 0; k < CSUM_LEN; k++) begin
                  push_char(ALPHABET[fin[25 - 5 * k +: 5]], (k == CSUM_LEN - 1), ERR_NONE);
               end
               clear_state();
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      addr_char_type want;
      if (reset) begin
         clear_state();
         expected_chars.delete();
         mismatches = 0;
      end else begin
         if (req.valid && req.ready) begin
            encode_request(req_kind_type'(req.req_type), req.prefix_char,
                           req.seg_version, req.program_byte);
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected response: out_char %0d last %0d error %0d",
                      rsp.out_char, rsp.last, rsp.error);
               mismatches++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp.out_char !== want.ch) begin
                  $error("out_char: expected %0d, got %0d", want.ch, rsp.out_char);
                  mismatches++;
               end
               if (rsp.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp.last);
                  mismatches++;
               end
               if (rsp.error !== want.err) begin
                  $error("error: expected %0d, got %0d", want.err, rsp.error);
                  mismatches++;
               end
            end
         end
      end
      expected_left <= expected_chars.size();
   end

endmodule

FILE: tb/tb_bech32m_address_encoder_top.sv
// tb_bech32m_address_encoder_top: drives address requests into the encoder with random
// idling and back-pressure, and gives the verdict from the checker's mismatch count
// depends on b32m_pkg, b32m_if, bech32m_address_encoder_top and b32m_addr_checker
`timescale 1ns / 100ps

module tb_bech32m_address_encoder_top;
   import b32m_pkg::*;

   localparam int PREFIX_MAX   = 83;
   localparam int PROGRAM_MAX  = 40;
   localparam int RANDOM_ITEMS = 120;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   expected_left;
   int   cycle_count = 0;
   int   items_sent  = 0;
   bit   no_idle     = 1'b0;
   bit   hold_rsp    = 1'b0;

   b32m_req_if req_ch ();
   b32m_rsp_if rsp_ch ();

   bech32m_address_encoder_top #(
      .MAX_PREFIX  (PREFIX_MAX),
      .MAX_PROGRAM (PROGRAM_MAX)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   b32m_addr_checker #(
      .MAX_PREFIX  (PREFIX_MAX),
      .MAX_PROGRAM (PROGRAM_MAX)
   ) addr_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .mismatches    (mismatches),
      .expected_left (expected_left)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_req(input req_kind_type kind, input logic [6:0] pc,
                           input logic [4:0] wv, input logic [7:0] pb);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= kind;
      req_ch.prefix_char  <= pc;
      req_ch.seg_version  <= wv;
      req_ch.program_byte <= pb;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic send_noise();
      send_req(req_kind_type'($urandom_range(0, 3)), 7'($urandom), 5'($urandom),
               8'($urandom));
   endtask

   task automatic send_address(input int plen, input logic [4:0] ver, input int blen,
                               input bit with_finish);
      for (int k = 0; k < plen; k++) begin
         send_req(REQ_PREFIX, 7'($urandom), 5'($urandom), 8'($urandom));
      end
      send_req(REQ_VERSION, 7'($urandom), ver, 8'($urandom));
      for (int k = 0; k < blen; k++) begin
         send_req(REQ_BYTE, 7'($urandom), 5'($urandom), 8'($urandom));
      end
      if (with_finish) begin
         send_req(REQ_FINISH, 7'($urandom), 5'($urandom), 8'($urandom));
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (expected_left != 0);
      @(posedge clock);
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp && !held) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      int         start_items;
      int         pick;
      logic [4:0] ver;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.req_type     <= REQ_PREFIX;
      req_ch.prefix_char  <= '0;
      req_ch.seg_version  <= '0;
      req_ch.program_byte <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // out of order while collecting the prefix
      send_req(REQ_FINISH, 7'h00, 5'd0, 8'h00);
      send_req(REQ_BYTE, 7'h00, 5'd0, 8'hff);
      // empty prefix, then finish with no program
      send_req(REQ_VERSION, 7'h00, 5'd0, 8'h00);
      send_req(REQ_FINISH, 7'h00, 5'd0, 8'h00);
      // prefix character after the version
      send_req(REQ_PREFIX, 7'h62, 5'd0, 8'h00);
      send_req(REQ_PREFIX, 7'h63, 5'd0, 8'h00);
      send_req(REQ_VERSION, 7'h00, 5'd0, 8'h00);
      send_req(REQ_PREFIX, 7'h7f, 5'd0, 8'h00);
      // second version, version above sixteen
      send_req(REQ_PREFIX, 7'h7f, 5'd0, 8'h00);
      send_req(REQ_PREFIX, 7'h00, 5'd0, 8'h00);
      send_req(REQ_VERSION, 7'h00, 5'd31, 8'h00);
      send_req(REQ_VERSION, 7'h00, 5'd16, 8'h00);
      // complete addresses, bech32m and bech32
      send_req(REQ_PREFIX, 7'h61, 5'd0, 8'h00);
      send_req(REQ_VERSION, 7'h00, 5'd16, 8'h00);
      send_req(REQ_BYTE, 7'h00, 5'd0, 8'hff);
      send_req(REQ_BYTE, 7'h00, 5'd0, 8'h00);
      send_req(REQ_BYTE, 7'h00, 5'd0, 8'ha5);
      send_req(REQ_FINISH, 7'h00, 5'd0, 8'h00);
      send_req(REQ_PREFIX, 7'h78, 5'd0, 8'h00);
      send_req(REQ_VERSION, 7'h00, 5'd0, 8'h00);
      send_req(REQ_BYTE, 7'h00, 5'd0, 8'h00);
      send_req(REQ_BYTE, 7'h00, 5'd0, 8'hff);
      send_req(REQ_FINISH, 7'h00, 5'd0, 8'h00);
      wait_drained();

      // longest prefix and program, then one past each limit
      send_address(PREFIX_MAX, 5'd1, PROGRAM_MAX, 1'b1);
      send_address(PREFIX_MAX + 1, 5'd0, 0, 1'b0);
      send_address(1, 5'd0, PROGRAM_MAX + 1, 1'b1);
      wait_drained();

      start_items = items_sent;
      hold_rsp    = 1'b1;
      while (items_sent - start_items < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         pick    = $urandom_range(0, 9);
         ver     = ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom);
         if (pick == 0) begin
            repeat ($urandom_range(1, 3)) send_noise();
         end else if (pick == 1) begin
            send_address($urandom_range(0, 5), ver, $urandom_range(0, 6), 1'b0);
            send_noise();
         end else begin
            send_address($urandom_range(0, 5), ver,
                         ($urandom_range(0, 9) == 0) ? $urandom_range(30, PROGRAM_MAX)
                                                     : $urandom_range(0, 12),
                         1'b1);
         end
         if ($urandom_range(0, 5) == 0) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/b32m_pkg.sv
rtl/b32m_if.sv
rtl/b32m_ctrl.sv
rtl/b32m_dp.sv
rtl/bech32m_address_encoder_top.sv
tb/b32m_addr_checker.sv
tb/tb_bech32m_address_encoder_top.sv
